/* hw/rtl/sfl_pkg.sv */
// shared types and constants for the struct field layout block
// used by every module under hw/rtl; no dependencies
package sfl_pkg;

  localparam int SizeW   = 24;
  localparam int AlignW  = 16;
  localparam int OffW    = 31;
  localparam int IndexW  = 6;
  localparam int PadW    = 16;

  localparam int DefaultMaxFieldCount = 64;

  // stream widths, fields packed from bit 0 and padded to whole bytes
  localparam int InDataW  = ((SizeW + AlignW + 7) / 8) * 8;
  localparam int OutBitsW = IndexW + OffW + PadW + OffW;
  localparam int OutDataW = ((OutBitsW + 7) / 8) * 8;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // latch the input beat
    logic start_div;   // launch a remainder pass
    logic div_end;     // divide by largest alignment instead of the field alignment
    logic commit;      // place the latched field at the rounded offset
    logic emit_mid;    // report the held field with padding up to the new start
    logic emit_final;  // report the held field as the struct's last, then clear
    logic clear;       // drop the struct state
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic out_free;
    logic held;
    logic over;
    logic last_now;
    logic last_q;
  } status_t;

endpackage

/* hw/rtl/struct_field_layout.sv */
// Struct field layout engine. Each input beat describes one struct field
// (size, alignment, last marker); the field is placed at the running offset
// rounded up to its alignment (zero counts as one) by a 31-step radix-2
// remainder unit; the next field is accepted only after this one is placed,
// and a last field adds a second 31-step pass after its own to round
// the struct end to the largest alignment seen. A field's result beat (index,
// offset, padding after it) leaves when the following field is placed; the last
// field's beat carries the tail padding, the total size and tlast. Fields past
// MAX_FIELD_COUNT are dropped, though their last marker still closes the
// struct. A result still waiting in the output register stalls the placement
// of the next field, and so the next accept, until it is taken.
// depends on sfl_pkg, sfl_ctrl and sfl_datapath
module struct_field_layout #(
  parameter int MAX_FIELD_COUNT = sfl_pkg::DefaultMaxFieldCount
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sfl_pkg::InDataW-1:0]   s_tdata,   // field_size, field_align
  input  logic                          s_tlast,   // last_field
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sfl_pkg::OutDataW-1:0]  m_tdata,   // field_index, field_offset,
                                                   // pad_after, struct_total
  output logic                          m_tlast    // result_last
);

  sfl_pkg::cmd_t    cmd;
  sfl_pkg::status_t status;

  sfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sfl_datapath #(
    .MAX_FIELD_COUNT (MAX_FIELD_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_ready_idle_div: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !status.div_busy)
    else $error("input ready while remainder unit busy");

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |-> !status.div_busy)
    else $error("remainder pass launched while busy");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_mid || cmd.emit_final) |-> status.out_free)
    else $error("result beat overwrites a waiting result");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_final |=> !status.held)
    else $error("struct state not cleared after final beat");
`endif

endmodule

/* hw/rtl/sfl_rem.sv */
// radix-2 restoring remainder unit: one dividend bit per cycle
// depends on sfl_pkg for the offset and alignment widths
module sfl_rem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sfl_pkg::OffW-1:0]    dividend,
  input  logic [sfl_pkg::AlignW-1:0]  divisor,
  output logic                        busy,
  output logic [sfl_pkg::AlignW-1:0]  rem,
  output logic [sfl_pkg::AlignW-1:0]  dvs
);

  localparam int CntW = $clog2(sfl_pkg::OffW);

  logic [CntW-1:0]             cnt;
  logic [sfl_pkg::OffW-1:0]    quo;
  logic [sfl_pkg::AlignW:0]    shifted;
  logic [sfl_pkg::AlignW:0]    diff;

  assign shifted = {rem, quo[sfl_pkg::OffW-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CntW'(sfl_pkg::OffW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[sfl_pkg::OffW-2:0], 1'b0};
      // keep the partial remainder only when the subtract would go negative
      if (diff[sfl_pkg::AlignW]) begin
        rem <= shifted[sfl_pkg::AlignW-1:0];
      end else begin
        rem <= diff[sfl_pkg::AlignW-1:0];
      end
    end
  end

endmodule

/* hw/rtl/sfl_datapath.sv */
// layout datapath: struct state, offset rounding, output register
// depends on sfl_pkg and instantiates sfl_rem
module sfl_datapath #(
  parameter int MAX_FIELD_COUNT = sfl_pkg::DefaultMaxFieldCount
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sfl_pkg::cmd_t                 cmd,
  output sfl_pkg::status_t              status,
  input  logic [sfl_pkg::InDataW-1:0]   in_data,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfl_pkg::OutDataW-1:0]  out_data,
  output logic                          out_last
);

  localparam int CntW = $clog2(MAX_FIELD_COUNT + 1);

  logic [sfl_pkg::SizeW-1:0]   in_size;
  logic [sfl_pkg::AlignW-1:0]  in_align;

  logic [sfl_pkg::SizeW-1:0]   size_q;
  logic [sfl_pkg::AlignW-1:0]  align_q;
  logic                        last_q;

  logic [sfl_pkg::OffW-1:0]    running;
  logic [sfl_pkg::OffW-1:0]    held_off;
  logic [sfl_pkg::SizeW-1:0]   held_size;
  logic [sfl_pkg::AlignW-1:0]  largest;
  logic [CntW-1:0]             cnt;

  logic [sfl_pkg::OffW-1:0]    running_next;
  logic [sfl_pkg::AlignW-1:0]  largest_next;
  logic [CntW-1:0]             cnt_next;

  logic                        div_busy;
  logic [sfl_pkg::AlignW-1:0]  rem;
  logic [sfl_pkg::AlignW-1:0]  dvs;
  logic [sfl_pkg::AlignW-1:0]  div_src;
  logic [sfl_pkg::AlignW-1:0]  div_in;

  logic [sfl_pkg::OffW-1:0]    rounded;
  logic [sfl_pkg::OffW-1:0]    held_end;
  logic [sfl_pkg::OffW-1:0]    gap;

  logic [sfl_pkg::IndexW-1:0]  o_index;
  logic [sfl_pkg::OffW-1:0]    o_offset;
  logic [sfl_pkg::PadW-1:0]    o_pad;
  logic [sfl_pkg::OffW-1:0]    o_total;

  assign in_size  = in_data[sfl_pkg::SizeW-1:0];
  assign in_align = in_data[sfl_pkg::SizeW +: sfl_pkg::AlignW];

  sfl_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (running_next),
    .divisor  (div_in),
    .busy     (div_busy),
    .rem      (rem),
    .dvs      (dvs)
  );

  // running offset rounded up to the divisor of the last remainder pass
  always_comb begin
    if (rem == '0) begin
      rounded = running;
    end else begin
      rounded = running + sfl_pkg::OffW'(dvs - rem);
    end
  end

  assign held_end = held_off + sfl_pkg::OffW'(held_size);
  assign gap      = rounded - held_end;

  always_comb begin
    running_next = running;
    largest_next = largest;
    cnt_next     = cnt;
    if (cmd.commit) begin
      running_next = rounded + sfl_pkg::OffW'(size_q);
      cnt_next     = cnt + 1'b1;
      if (align_q > largest) begin
        largest_next = align_q;
      end
    end
  end

  // alignment zero divides by one
  assign div_src = cmd.div_end ? largest_next : in_align;
  assign div_in  = (div_src == '0) ? sfl_pkg::AlignW'(1) : div_src;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      size_q  <= in_size;
      align_q <= in_align;
      last_q  <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
      largest <= '0;
      cnt     <= '0;
    end else if (cmd.clear || cmd.emit_final) begin
      running <= '0;
      largest <= '0;
      cnt     <= '0;
    end else begin
      running <= running_next;
      largest <= largest_next;
      cnt     <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      held_off  <= rounded;
      held_size <= size_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_mid || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_mid || cmd.emit_final) begin
      o_index  <= sfl_pkg::IndexW'(cnt - 1'b1);
      o_offset <= held_off;
      o_pad    <= gap[sfl_pkg::PadW-1:0];
      o_total  <= cmd.emit_final ? rounded : '0;
      out_last <= cmd.emit_final;
    end
  end

  assign out_data = {{(sfl_pkg::OutDataW - sfl_pkg::OutBitsW){1'b0}},
                     o_total, o_pad, o_offset, o_index};

  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || out_ready;
  assign status.held     = (cnt != '0);
  assign status.over     = (cnt >= CntW'(MAX_FIELD_COUNT));
  assign status.last_now = in_last;
  assign status.last_q   = last_q;

endmodule

/* hw/rtl/sfl_ctrl.sv */
// layout controller: sequences accept, remainder passes and result beats
// depends on sfl_pkg for the command and status structs
module sfl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfl_pkg::status_t  status,
  output sfl_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    IDLE,
    FIELD_DIV,
    END_DIV
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          if (status.over) begin
            // extra fields are dropped, a last marker still closes the struct
            if (status.last_now && status.held) begin
              cmd.start_div = 1'b1;
              cmd.div_end   = 1'b1;
              state_next    = END_DIV;
            end else if (status.last_now) begin
              cmd.clear = 1'b1;
            end
          end else begin
            cmd.start_div = 1'b1;
            state_next    = FIELD_DIV;
          end
        end
      end
      FIELD_DIV: begin
        if (!status.div_busy && (status.out_free || !status.held)) begin
          cmd.commit   = 1'b1;
          cmd.emit_mid = status.held;
          if (status.last_q) begin
            cmd.start_div = 1'b1;
            cmd.div_end   = 1'b1;
            state_next    = END_DIV;
          end else begin
            state_next = IDLE;
          end
        end
      end
      END_DIV: begin
        if (!status.div_busy && status.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == IDLE);
    end
  end

endmodule

/* bench/struct_field_layout_tb.sv */
// testbench for struct_field_layout: streams struct fields in, predicts each
// field's offset, padding and struct total, and checks every result beat
// depends on sfl_pkg and the struct_field_layout rtl
`timescale 1ns / 100ps

module struct_field_layout_tb;
  import sfl_pkg::*;

  localparam int MaxFields  = DefaultMaxFieldCount;
  localparam int CycleLimit = 600000;
  localparam int ItemTarget = 700;
  localparam int OffLo      = IndexW;
  localparam int PadLo      = IndexW + OffW;
  localparam int TotLo      = IndexW + OffW + PadW;

  typedef struct {
    logic [SizeW-1:0]  size;
    logic [AlignW-1:0] align;
    logic              last;
    logic              drain_first;  // hold this beat until all results are back
  } field_beat_t;

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [OffW-1:0]   offset;
    logic [PadW-1:0]   pad;
    logic [OffW-1:0]   total;
    logic              last;
  } layout_report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  field_beat_t    pending_fields[$];
  layout_report_t expected_reports[$];
  logic           in_taken = 1'b0;
  int             cycle_cnt = 0;
  int             errors = 0;
  int             mismatches = 0;
  logic           calm;

  // layout state mirrored from the block
  logic [OffW-1:0]   running_off;
  logic [OffW-1:0]   held_off;
  logic [SizeW-1:0]  held_size;
  logic              held_valid;
  logic [AlignW-1:0] largest_align;
  logic [6:0]        fields_seen;

  struct_field_layout #(.MAX_FIELD_COUNT(MaxFields)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign calm = (cycle_cnt >= 6000) && (cycle_cnt < 14000);

  function automatic logic [OffW-1:0] round_to_align(logic [OffW-1:0] off,
                                                      logic [AlignW-1:0] a);
    logic [31:0] rem;
    if (a == '0) return off;
    rem = off % a;
    if (rem != 0) return OffW'(off + (a - rem));
    return off;
  endfunction

  task automatic clear_layout();
    running_off   = '0;
    held_off      = '0;
    held_size     = '0;
    held_valid    = 1'b0;
    largest_align = '0;
    fields_seen   = '0;
  endtask

  task automatic queue_report(logic [6:0] idx, logic [OffW-1:0] off,
                              logic [OffW-1:0] gap, logic [OffW-1:0] tot,
                              logic fin);
    layout_report_t r;
    r.index  = idx[IndexW-1:0];
    r.offset = off;
    r.pad    = gap[PadW-1:0];
    r.total  = tot;
    r.last   = fin;
    expected_reports.push_back(r);
  endtask

  // one accepted field: report the held field, then the new one if it closes
  task automatic place_field(logic [SizeW-1:0] size, logic [AlignW-1:0] align,
                             logic fin);
    logic [AlignW-1:0] a;
    logic [OffW-1:0]   start;
    logic [OffW-1:0]   fend;
    logic [OffW-1:0]   hend;
    logic [OffW-1:0]   tail_end;
    if (fields_seen >= MaxFields) begin
      // overflow fields are dropped, but their last marker closes the struct
      if (fin) begin
        if (held_valid) begin
          tail_end = round_to_align(running_off, largest_align);
          hend     = held_off + OffW'(held_size);
          queue_report(fields_seen - 7'd1, held_off, tail_end - hend, tail_end, 1'b1);
        end
        clear_layout();
      end
    end else begin
      a     = (align == '0) ? AlignW'(1) : align;
      start = round_to_align(running_off, a);
      if (held_valid) begin
        hend = held_off + OffW'(held_size);
        queue_report(fields_seen - 7'd1, held_off, start - hend, '0, 1'b0);
      end
      if (align > largest_align) largest_align = align;
      fend        = start + OffW'(size);
      running_off = fend;
      held_off    = start;
      held_size   = size;
      held_valid  = 1'b1;
      fields_seen = fields_seen + 7'd1;
      if (fin) begin
        tail_end = round_to_align(fend, largest_align);
        queue_report(fields_seen - 7'd1, start, tail_end - fend, tail_end, 1'b1);
        clear_layout();
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !in_taken)) begin
      if (pending_fields.size() != 0 && (calm || $urandom_range(99) >= 19) &&
          !(pending_fields[0].drain_first && expected_reports.size() != 0)) begin
        s_tdata  <= {pending_fields[0].align, pending_fields[0].size};
        s_tlast  <= pending_fields[0].last;
        s_tvalid <= 1'b1;
        void'(pending_fields.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 19);
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    layout_report_t got;
    layout_report_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst) begin
      clear_layout();
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        place_field(s_tdata[SizeW-1:0], s_tdata[SizeW +: AlignW], s_tlast);
      if (m_tvalid && m_tready) begin
        got.index  = m_tdata[IndexW-1:0];
        got.offset = m_tdata[OffLo +: OffW];
        got.pad    = m_tdata[PadLo +: PadW];
        got.total  = m_tdata[TotLo +: OffW];
        got.last   = m_tlast;
        if (expected_reports.size() == 0) begin
          errors = errors + 1;
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result beat: index %0d offset %0d",
                     " pad %0d total %0d last %0b",
                     got.index, got.offset, got.pad, got.total, got.last);
        end else begin
          want = expected_reports.pop_front();
          if (got.index !== want.index || got.offset !== want.offset ||
              got.pad !== want.pad || got.total !== want.total || got.last !== want.last) begin
            errors = errors + 1;
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: exp idx %0d off %0d pad %0d tot %0d last %0b",
                       " / got idx %0d off %0d pad %0d tot %0d last %0b",
                       want.index, want.offset, want.pad, want.total, want.last,
                       got.index, got.offset, got.pad, got.total, got.last);
          end
        end
      end
    end
  end

  function automatic logic [SizeW-1:0] pick_size();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return SizeW'($urandom_range(0, 64));
      5, 6:          return SizeW'($urandom_range(0, 4096));
      7:             return SizeW'($urandom);
      8:             return '0;
      default:       return '1;
    endcase
  endfunction

  function automatic logic [AlignW-1:0] pick_align();
    case ($urandom_range(9))
      0:          return '0;
      1, 2, 3:    return AlignW'(1) << $urandom_range(0, 4);
      4, 5:       return AlignW'($urandom_range(1, 24));
      6:          return AlignW'($urandom);
      7:          return '1;
      8:          return AlignW'(1) << $urandom_range(5, 15);
      default:    return AlignW'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic add_field(logic [SizeW-1:0] size, logic [AlignW-1:0] align,
                           logic fin, logic drain);
    field_beat_t b;
    b.size        = size;
    b.align       = align;
    b.last        = fin;
    b.drain_first = drain;
    pending_fields.push_back(b);
  endtask

  initial begin
    int placed;
    int len;
    int structs;
    placed  = 0;
    structs = 0;

    // single zero field, zero alignment
    add_field('0, '0, 1'b1, 1'b0);
    // extremes and odd alignments
    add_field('1, '1, 1'b0, 1'b0);
    add_field(24'd1, 16'd3, 1'b0, 1'b0);
    add_field(24'd5, 16'd7, 1'b0, 1'b0);
    add_field('0, '0, 1'b0, 1'b0);
    add_field(24'd2, 16'd12, 1'b0, 1'b0);
    add_field(24'd9, 16'd1, 1'b1, 1'b0);
    // no alignment anywhere, end is not rounded
    add_field(24'd3, '0, 1'b0, 1'b0);
    add_field(24'd5, '0, 1'b0, 1'b0);
    add_field(24'd7, '0, 1'b1, 1'b0);
    // tail padding from a non power of two largest alignment
    add_field(24'd1, 16'd1, 1'b0, 1'b0);
    add_field(24'd3, 16'd6, 1'b0, 1'b0);
    add_field(24'd1, 16'd10, 1'b1, 1'b0);
    // alternating bit patterns
    add_field(24'hAAAAAA, 16'h5555, 1'b0, 1'b0);
    add_field(24'h555555, 16'hAAAA, 1'b0, 1'b0);
    add_field(24'd17, 16'h8000, 1'b1, 1'b0);
    add_field(24'h7FFFFF, 16'd65534, 1'b0, 1'b0);
    add_field(24'd1, 16'd2, 1'b1, 1'b0);

    while (placed < ItemTarget) begin
      // an occasional struct runs near or past the field limit
      if ($urandom_range(11) == 0) len = $urandom_range(MaxFields - 4, MaxFields + 12);
      else len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
        add_field(pick_size(), pick_align(), i == len - 1,
                  (i == 0) && (structs % 25 == 7));
      placed  = placed + ((len > MaxFields) ? MaxFields : len);
      structs = structs + 1;
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    while (pending_fields.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);

    if (errors == 0 && expected_reports.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sfl_pkg.sv
hw/rtl/sfl_rem.sv
hw/rtl/sfl_datapath.sv
hw/rtl/sfl_ctrl.sv
hw/rtl/struct_field_layout.sv
bench/struct_field_layout_tb.sv
